@@ sv/oatp_pkg.sv @@
// Shared types and constants of the onset picker.
// Used by every module of the block but oatp_ram; depends on nothing.
`default_nettype none

package oatp_pkg;

    // Fixed point format of the normalized history values
    localparam int FRAC_BITS = 16;
    localparam int HIST_W    = FRAC_BITS + 1;
    localparam int VAL_W     = 32;
    // Divider: dividend is value times history entry, quotient fits HIST_W bits
    localparam int DIV_NW    = VAL_W + HIST_W;
    // Widest slot index carried in the command word
    localparam int IDX_W     = 8;

    // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x below 2^19
    localparam logic [17:0] DIV3_MUL   = 18'd174763;
    localparam int          DIV3_SHIFT = 19;

    // Register map (word index)
    typedef enum logic [2:0] {
        REG_SILENCE   = 3'd0,
        REG_ALPHA     = 3'd1,
        REG_CH_EN     = 3'd2,
        REG_REF_EN    = 3'd3,
        REG_REF_MODE  = 3'd4,
        REG_MIN_MS    = 3'd5,
        REG_MIN_FR    = 3'd6
    } reg_idx_t;

    localparam logic [16:0] RST_SILENCE  = 17'd1311;
    localparam logic [16:0] RST_ALPHA    = 17'd6554;
    localparam logic [2:0]  RST_CH_EN    = 3'd7;
    localparam logic        RST_REF_EN   = 1'b1;
    localparam logic        RST_REF_MODE = 1'b0;
    localparam logic [15:0] RST_MIN_MS   = 16'd100;
    localparam logic [9:0]  RST_MIN_FR   = 10'd7;

    typedef struct packed {
        logic [16:0] silence;
        logic [16:0] alpha;
        logic [2:0]  ch_en;
        logic        ref_en;
        logic        ref_mode;
        logic [15:0] min_ms;
        logic [9:0]  min_fr;
    } cfg_t;

    // Divider operand source
    typedef enum logic [1:0] {
        DIV_RESCALE = 2'd0,
        DIV_NORM    = 2'd1
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHK,
        ST_RS_READ,
        ST_RS_MUL,
        ST_RS_DIV,
        ST_RS_WAIT,
        ST_NM_START,
        ST_NM_WAIT,
        ST_ADV,
        ST_CB_RUN,
        ST_CB_DRAIN,
        ST_MEAN,
        ST_SEL_RUN,
        ST_SEL_DRAIN,
        ST_SEL_DECIDE,
        ST_PROD,
        ST_DECIDE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic             load_in;
        logic [1:0]       ch;
        logic [IDX_W-1:0] idx;
        logic             rs_mul;
        logic             div_start;
        div_sel_t         div_sel;
        logic             rs_write;
        logic             set_max;
        logic             nm_write;
        logic             advance;
        logic             cb_read;
        logic             mean_take;
        logic             sel_read;
        logic             sel_decide;
        logic             prod;
        logic             decide;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic grow;
        logic max_zero;
        logic div_done;
        logic sel_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ sv/oatp_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module oatp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ sv/oatp_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Needs dividend < divisor * 2^HIST_W; depends on oatp_pkg.
`default_nettype none

module oatp_div import oatp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] dividend,
    input  wire logic [VAL_W-1:0]  divisor,
    output logic                   busy,
    output logic                   done,
    output logic [HIST_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(HIST_W + 1);

    logic [VAL_W-1:0]  rem_reg;
    logic [HIST_W-1:0] low_reg;
    logic [VAL_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [VAL_W:0]    trial;
    logic [VAL_W:0]    diff;
    logic              ge;

    // One restoring step
    assign trial = {rem_reg, low_reg[HIST_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= dividend[DIV_NW-1:HIST_W];
                low_reg  <= dividend[HIST_W-1:0];
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(HIST_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
                low_reg <= {low_reg[HIST_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

`default_nettype wire

@@ sv/oatp_datapath.sv @@
// Datapath: history RAMs, running maxima, combine, median select, threshold.
// Depends on oatp_pkg, oatp_ram and oatp_div.
`default_nettype none

module oatp_datapath import oatp_pkg::*; #(
    parameter int HISTORY_DEPTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmd_t             cmd,
    output sts_t                  sts,
    input  wire cfg_t             cfg,
    input  wire logic [VAL_W-1:0] hfc_value,
    input  wire logic [VAL_W-1:0] complex_value,
    input  wire logic [VAL_W-1:0] flux_value,
    input  wire logic [VAL_W-1:0] time_ms,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic                  onset,
    output logic [HIST_W-1:0]     strength
);

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int SW   = $clog2(HISTORY_DEPTH) + HIST_W;
    localparam int PW   = 2 * HIST_W;
    localparam logic [AW:0] DEPTH_A = (AW+1)'(HISTORY_DEPTH);
    localparam logic [CW:0] DEPTH_C = (CW+1)'(HISTORY_DEPTH);
    localparam logic [CW-1:0] MED_RANK = CW'(HISTORY_DEPTH / 2);

    logic [VAL_W-1:0]  val_reg [3];
    logic [VAL_W-1:0]  max_reg [3];
    logic [VAL_W-1:0]  time_reg;
    logic [AW-1:0]     ptr_reg;
    logic [CW-1:0]     fill_reg;
    logic [DIV_NW-1:0] rs_prod_reg;
    logic [SW-1:0]     sum_reg;
    logic [HIST_W-1:0] newest_reg;
    logic [HIST_W-1:0] mean_reg;
    logic [HIST_W-1:0] pre_reg;
    logic [HIST_W-1:0] above_reg;
    logic [HIST_W-1:0] bsel_reg;
    logic [CW-1:0]     k_reg;
    logic [CW-1:0]     cnt_reg;
    logic              sel_vld_reg;
    logic              cb_vld_reg;
    logic [AW-1:0]     cb_idx_reg;
    logic [PW-1:0]     thr_prod_reg;
    logic [VAL_W-1:0]  last_time_reg;
    logic [VAL_W-1:0]  frame_reg;
    logic [VAL_W-1:0]  last_frame_reg;
    logic              m_tvalid_reg;
    logic              onset_reg;
    logic [HIST_W-1:0] strength_reg;

    logic [AW-1:0]     idx;
    logic [AW:0]       rot_sum;
    logic [AW-1:0]     rot;
    logic [HIST_W-1:0] h_rdata [3];
    logic [HIST_W-1:0] c_rdata;
    logic [DIV_NW-1:0] div_dvd;
    logic [VAL_W-1:0]  div_dvs;
    logic              div_busy;
    logic              div_done;
    logic [HIST_W-1:0] div_q;
    logic              max_zero;
    logic [AW-1:0]     h_waddr;
    logic [HIST_W-1:0] h_wdata;
    logic [AW-1:0]     h_raddr;

    assign idx      = cmd.idx[AW-1:0];
    assign max_zero = (max_reg[cmd.ch] == '0);

    // Logical slot to physical address: oldest entry sits at ptr_reg
    assign rot_sum = {1'b0, ptr_reg} + {1'b0, idx};
    assign rot     = (rot_sum >= DEPTH_A) ? AW'(rot_sum - DEPTH_A) : rot_sum[AW-1:0];

    assign h_waddr = cmd.rs_write ? idx : ptr_reg;
    assign h_wdata = (cmd.nm_write && max_zero) ? '0 : div_q;
    assign h_raddr = cmd.cb_read ? rot : idx;

    // One history RAM per channel
    for (genvar c = 0; c < 3; c++) begin : g_hist
        oatp_ram #(
            .WIDTH (HIST_W),
            .DEPTH (HISTORY_DEPTH)
        ) u_hist (
            .aclk  (aclk),
            .we    ((cmd.rs_write || cmd.nm_write) && (cmd.ch == 2'(c))),
            .waddr (h_waddr),
            .wdata (h_wdata),
            .raddr (h_raddr),
            .rdata (h_rdata[c])
        );
    end

    // Combine: mask invalid slots and disabled channels, average, silence gate
    logic [CW:0]       vsum;
    logic              slot_valid;
    logic [HIST_W-1:0] term [3];
    logic [HIST_W+1:0] csum;
    logic [HIST_W+1+18:0] c3_prod;
    logic [1:0]        n_en;
    logic [HIST_W-1:0] avg;
    logic [HIST_W-1:0] comb_val;

    assign vsum       = (CW+1)'(cb_idx_reg) + (CW+1)'(fill_reg);
    assign slot_valid = (vsum >= DEPTH_C);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            term[c] = (slot_valid && cfg.ch_en[c]) ? h_rdata[c] : '0;
        end
    end

    assign csum    = (HIST_W+2)'(term[0]) + (HIST_W+2)'(term[1]) + (HIST_W+2)'(term[2]);
    assign c3_prod = csum * DIV3_MUL;
    assign n_en    = 2'(cfg.ch_en[0]) + 2'(cfg.ch_en[1]) + 2'(cfg.ch_en[2]);

    always_comb begin
        case (n_en)
            2'd1:    avg = csum[HIST_W-1:0];
            2'd2:    avg = csum[HIST_W:1];
            2'd3:    avg = c3_prod[DIV3_SHIFT+HIST_W-1:DIV3_SHIFT];
            default: avg = '0;
        endcase
    end

    assign comb_val = (avg < cfg.silence) ? '0 : avg;

    // Combined window store
    oatp_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_comb (
        .aclk  (aclk),
        .we    (cb_vld_reg),
        .waddr (cb_idx_reg),
        .wdata (comb_val),
        .raddr (idx),
        .rdata (c_rdata)
    );

    // Shared divider operands
    always_comb begin
        case (cmd.div_sel)
            DIV_RESCALE: begin
                div_dvd = rs_prod_reg;
                div_dvs = val_reg[cmd.ch];
            end
            DIV_NORM: begin
                div_dvd = DIV_NW'({val_reg[cmd.ch], {FRAC_BITS{1'b0}}});
                div_dvs = max_reg[cmd.ch];
            end
            default: begin
                div_dvd = '0;
                div_dvs = '1;
            end
        endcase
    end

    oatp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Radix select match for the current bit
    logic sel_match;
    assign sel_match = ((c_rdata & above_reg) == (pre_reg & above_reg)) &&
                       ((c_rdata & bsel_reg) == '0);

    // Threshold compare and refractory check
    logic [HIST_W+1:0] thr;
    logic              cand;
    logic [VAL_W-1:0]  el_ms;
    logic [VAL_W-1:0]  el_fr;
    logic              onset_next;
    logic              take_ms;
    logic              take_fr;

    assign thr   = (HIST_W+2)'(pre_reg) + (HIST_W+2)'(thr_prod_reg[PW-1:FRAC_BITS]);
    assign cand  = (HIST_W+2)'(newest_reg) > thr;
    assign el_ms = time_reg - last_time_reg;
    assign el_fr = frame_reg - last_frame_reg;

    always_comb begin
        onset_next = cand;
        take_ms    = 1'b0;
        take_fr    = 1'b0;
        if (cfg.ref_en && cand) begin
            if (!cfg.ref_mode) begin
                onset_next = el_ms > VAL_W'(cfg.min_ms);
                take_ms    = onset_next;
            end else begin
                onset_next = el_fr > VAL_W'(cfg.min_fr);
                take_fr    = onset_next;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                max_reg[c] <= '0;
            end
            ptr_reg        <= '0;
            fill_reg       <= '0;
            sel_vld_reg    <= 1'b0;
            cb_vld_reg     <= 1'b0;
            last_time_reg  <= '0;
            frame_reg      <= '0;
            last_frame_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            sel_vld_reg <= cmd.sel_read;
            cb_vld_reg  <= cmd.cb_read;
            if (cmd.set_max) begin
                max_reg[cmd.ch] <= val_reg[cmd.ch];
            end
            if (cmd.advance) begin
                ptr_reg <= (ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                if (fill_reg != CW'(HISTORY_DEPTH)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.decide) begin
                m_tvalid_reg <= 1'b1;
                if (take_ms) begin
                    last_time_reg <= time_reg;
                end
                if (take_fr) begin
                    last_frame_reg <= frame_reg;
                end
                if (cfg.ref_mode) begin
                    frame_reg <= frame_reg + 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            val_reg[0] <= hfc_value;
            val_reg[1] <= complex_value;
            val_reg[2] <= flux_value;
            time_reg   <= time_ms;
            sum_reg    <= '0;
            pre_reg    <= '0;
            above_reg  <= '0;
            bsel_reg   <= {1'b1, {(HIST_W-1){1'b0}}};
            k_reg      <= MED_RANK;
            cnt_reg    <= '0;
        end
        if (cmd.rs_mul) begin
            rs_prod_reg <= DIV_NW'(h_rdata[cmd.ch]) * DIV_NW'(max_reg[cmd.ch]);
        end
        if (cb_vld_reg) begin
            sum_reg <= sum_reg + SW'(comb_val);
            if (cb_idx_reg == AW'(HISTORY_DEPTH - 1)) begin
                newest_reg <= comb_val;
            end
        end
        if (cmd.cb_read) begin
            cb_idx_reg <= idx;
        end
        // Window mean: depth is a power of two, so a shift
        if (cmd.mean_take) begin
            mean_reg <= sum_reg[SW-1:AW];
        end
        if (sel_vld_reg && sel_match) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.sel_decide) begin
            if (k_reg >= cnt_reg) begin
                pre_reg <= pre_reg | bsel_reg;
                k_reg   <= k_reg - cnt_reg;
            end
            cnt_reg   <= '0;
            above_reg <= above_reg | bsel_reg;
            bsel_reg  <= bsel_reg >> 1;
        end
        if (cmd.prod) begin
            thr_prod_reg <= cfg.alpha * mean_reg;
        end
        if (cmd.decide) begin
            onset_reg    <= onset_next;
            strength_reg <= newest_reg;
        end
    end

    assign sts.grow     = val_reg[cmd.ch] > max_reg[cmd.ch];
    assign sts.max_zero = max_zero;
    assign sts.div_done = div_done;
    assign sts.sel_last = bsel_reg[0];
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign onset    = onset_reg;
    assign strength = strength_reg;

`ifndef ASSERT_OFF
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(HISTORY_DEPTH))
        else $error("fill count beyond depth");
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= AW'(HISTORY_DEPTH - 1))
        else $error("history pointer out of range");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten before taken");
    a_out_set: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |=> m_tvalid_reg)
        else $error("result word not presented");
`endif

endmodule

`default_nettype wire

@@ sv/oatp_ctrl.sv @@
// Controller: sequences rescale, normalize, combine, mean, median select, decide.
// Depends on oatp_pkg.
`default_nettype none

module oatp_ctrl import oatp_pkg::*; #(
    parameter int HISTORY_DEPTH = 32
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

    state_t        state_reg, state_next;
    logic [1:0]    ch_reg, ch_next;
    logic [AW-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        cmd.ch      = ch_reg;
        cmd.idx     = IDX_W'(idx_reg);
        cmd.div_sel = DIV_RESCALE;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    ch_next     = '0;
                    state_next  = ST_CHK;
                end
            end
            ST_CHK: begin
                idx_next   = '0;
                state_next = sts.grow ? ST_RS_READ : ST_NM_START;
            end
            ST_RS_READ: begin
                state_next = ST_RS_MUL;
            end
            ST_RS_MUL: begin
                cmd.rs_mul = 1'b1;
                state_next = ST_RS_DIV;
            end
            ST_RS_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_RS_WAIT;
            end
            ST_RS_WAIT: begin
                if (sts.div_done) begin
                    cmd.rs_write = 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        cmd.set_max = 1'b1;
                        state_next  = ST_NM_START;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RS_READ;
                    end
                end
            end
            ST_NM_START: begin
                cmd.div_sel = DIV_NORM;
                if (sts.max_zero) begin
                    cmd.nm_write = 1'b1;
                    if (ch_reg == 2'd2) begin
                        state_next = ST_ADV;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_CHK;
                    end
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_NM_WAIT;
                end
            end
            ST_NM_WAIT: begin
                if (sts.div_done) begin
                    cmd.nm_write = 1'b1;
                    if (ch_reg == 2'd2) begin
                        state_next = ST_ADV;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_CHK;
                    end
                end
            end
            ST_ADV: begin
                cmd.advance = 1'b1;
                idx_next    = '0;
                state_next  = ST_CB_RUN;
            end
            ST_CB_RUN: begin
                cmd.cb_read = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_CB_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CB_DRAIN: begin
                state_next = ST_MEAN;
            end
            ST_MEAN: begin
                cmd.mean_take = 1'b1;
                idx_next      = '0;
                state_next    = ST_SEL_RUN;
            end
            ST_SEL_RUN: begin
                cmd.sel_read = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_SEL_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SEL_DRAIN: begin
                state_next = ST_SEL_DECIDE;
            end
            ST_SEL_DECIDE: begin
                cmd.sel_decide = 1'b1;
                idx_next       = '0;
                state_next     = sts.sel_last ? ST_PROD : ST_SEL_RUN;
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (sts.out_free) begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/onset_adaptive_threshold_picker.sv @@
// Onset picker top level: APB register file, stream ports, controller and datapath.
// Depends on oatp_pkg, oatp_ctrl and oatp_datapath.
//
//  channel   direction  word / payload
//  s_        in         hfc, complex, flux, time_ms (4 x 32 bits)
//  m_        out        onset, strength (1 + 17 bits)
//  APB       in/out     7 configuration registers at 4*index
//
// The time taken per word grows with HISTORY_DEPTH, and grows further for
// each channel whose running maximum grows. The 17 radix-select passes over
// the window RAM and the bit-serial divider account for this time.
// HISTORY_DEPTH must be a power of two. Words are processed one at a time;
// the next word is taken while a result waits on m_.
// Synchronous active-low reset; no clearing pass, history validity is
// tracked by a fill count.
`default_nettype none

module onset_adaptive_threshold_picker import oatp_pkg::*; #(
    parameter int HISTORY_DEPTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // [31:0] hfc_value, [63:32] complex_value, [95:64] flux_value, [127:96] time_ms
    input  wire logic [127:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [0] onset, [17:1] strength, [23:18] zero
    output logic [23:0]       m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t              cfg_reg;
    cmd_t              cmd;
    sts_t              sts;
    logic              onset;
    logic [HIST_W-1:0] strength;
    reg_idx_t          ridx;

    assign ridx   = reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.silence  <= RST_SILENCE;
            cfg_reg.alpha    <= RST_ALPHA;
            cfg_reg.ch_en    <= RST_CH_EN;
            cfg_reg.ref_en   <= RST_REF_EN;
            cfg_reg.ref_mode <= RST_REF_MODE;
            cfg_reg.min_ms   <= RST_MIN_MS;
            cfg_reg.min_fr   <= RST_MIN_FR;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_SILENCE:  cfg_reg.silence  <= pwdata[16:0];
                REG_ALPHA:    cfg_reg.alpha    <= pwdata[16:0];
                REG_CH_EN:    cfg_reg.ch_en    <= pwdata[2:0];
                REG_REF_EN:   cfg_reg.ref_en   <= pwdata[0];
                REG_REF_MODE: cfg_reg.ref_mode <= pwdata[0];
                REG_MIN_MS:   cfg_reg.min_ms   <= pwdata[15:0];
                REG_MIN_FR:   cfg_reg.min_fr   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (ridx)
            REG_SILENCE:  prdata = 32'(cfg_reg.silence);
            REG_ALPHA:    prdata = 32'(cfg_reg.alpha);
            REG_CH_EN:    prdata = 32'(cfg_reg.ch_en);
            REG_REF_EN:   prdata = 32'(cfg_reg.ref_en);
            REG_REF_MODE: prdata = 32'(cfg_reg.ref_mode);
            REG_MIN_MS:   prdata = 32'(cfg_reg.min_ms);
            REG_MIN_FR:   prdata = 32'(cfg_reg.min_fr);
            default:      prdata = '0;
        endcase
    end

    oatp_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    oatp_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg           (cfg_reg),
        .hfc_value     (s_tdata[31:0]),
        .complex_value (s_tdata[63:32]),
        .flux_value    (s_tdata[95:64]),
        .time_ms       (s_tdata[127:96]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .onset         (onset),
        .strength      (strength)
    );

    assign m_tdata = {6'd0, strength, onset};

endmodule

`default_nettype wire
